// ===== rtl/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared constants and types of the trial division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

   localparam int VALUE_BITS = 31;
   localparam int STEP_BITS  = $clog2(VALUE_BITS);

   localparam logic [VALUE_BITS-1:0] FIRST_DIVISOR = VALUE_BITS'(2);
   localparam logic [STEP_BITS-1:0]  LAST_STEP     = STEP_BITS'(VALUE_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [VALUE_BITS-1:0] dividend;
      logic [VALUE_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] quotient;
      logic [VALUE_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/tdf_channels.sv =====
// ----------------------------------------------------------------------------
// tdf_channels
// Valid/ready channel interfaces for the factorizer's input and results.
// ----------------------------------------------------------------------------
interface tdf_req_if;
   logic                           valid;
   logic                           ready;
   logic [tdf_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface tdf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tdf_pkg::VALUE_BITS-1:0] prime_factor;
   logic                           last_factor;
   logic                           no_factors;

   modport source (output valid, output prime_factor, output last_factor,
                   output no_factors, input ready);
   modport sink   (input valid, input prime_factor, input last_factor,
                   input no_factors, output ready);
endinterface

// ===== rtl/tdf_divider.sv =====
// ----------------------------------------------------------------------------
// tdf_divider
// Restoring radix-2 divider: one quotient bit per cycle, quotient and
// remainder valid with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module tdf_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tdf_pkg::div_req_type div_req,
   output tdf_pkg::div_rsp_type div_rsp
);
   import tdf_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] divisor_ff, divisor_in;
   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   diff;

   always_comb begin
      shifted    = {rem_ff, quo_ff[VALUE_BITS-1]};
      diff       = shifted - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // restore when the trial subtract goes negative
         if (diff[VALUE_BITS]) begin
            rem_in = shifted[VALUE_BITS-1:0];
            quo_in = {quo_ff[VALUE_BITS-2:0], 1'b0};
         end else begin
            rem_in = diff[VALUE_BITS-1:0];
            quo_in = {quo_ff[VALUE_BITS-2:0], 1'b1};
         end
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== rtl/trial_division_factorizer.sv =====
// ----------------------------------------------------------------------------
// trial_division_factorizer
// Emits the prime factors of an unsigned integer in nondecreasing order.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one value per transfer; rsp_if returns one result per
//   prime factor, repeats included, with last_factor set on the final one.
//   A value of 0 or 1 gives a single result with prime_factor 0 and
//   no_factors set.
//   Each divisor test is one pass through a shared bit-serial divider that
//   yields quotient and remainder together. Divisors are tested in rising
//   order from 2 while the divisor squared stays within the remainder, so
//   a large prime tests up to about sqrt(value) divisors.
//   req_if.ready is high only while the block is idle; one item is worked on
//   at a time.
//   A stalled receiver holds the current result in the output register and
//   pauses the factor search until the transfer completes.
//   Reset returns the sequencer to idle and drops any pending result.
// ----------------------------------------------------------------------------
module trial_division_factorizer (
   input  logic      clock,
   input  logic      reset,
   tdf_req_if.sink   req_if,
   tdf_rsp_if.source rsp_if
);
   import tdf_pkg::*;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] remain_ff, remain_in;
   logic [VALUE_BITS-1:0] divisor_ff, divisor_in;
   logic [VALUE_BITS-1:0] factor_ff, factor_in;
   logic                  last_ff, last_in;
   logic                  none_ff, none_in;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   tdf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in         = state_ff;
      remain_in        = remain_ff;
      divisor_in       = divisor_ff;
      factor_in        = factor_ff;
      last_in          = last_ff;
      none_in          = none_ff;
      div_req.start    = 1'b0;
      div_req.dividend = remain_ff;
      div_req.divisor  = divisor_ff;
      req_if.ready     = 1'b0;
      rsp_if.valid     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               remain_in  = req_if.value;
               divisor_in = FIRST_DIVISOR;
               if (req_if.value < FIRST_DIVISOR) begin
                  factor_in = '0;
                  last_in   = 1'b1;
                  none_in   = 1'b1;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            div_req.start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               none_in = 1'b0;
               // divisor squared still within the remainder
               if (divisor_ff <= div_rsp.quotient) begin
                  if (div_rsp.remainder == '0) begin
                     factor_in = divisor_ff;
                     last_in   = 1'b0;
                     remain_in = div_rsp.quotient;
                     state_in  = ST_EMIT;
                  end else begin
                     divisor_in = divisor_ff + VALUE_BITS'(1);
                     state_in   = ST_START;
                  end
               end else begin
                  factor_in = remain_ff;
                  last_in   = 1'b1;
                  state_in  = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            rsp_if.valid = 1'b1;
            if (rsp_if.ready) begin
               state_in = last_ff ? ST_IDLE : ST_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      remain_ff  <= remain_in;
      divisor_ff <= divisor_in;
      factor_ff  <= factor_in;
      last_ff    <= last_in;
      none_ff    <= none_in;
   end

   assign rsp_if.prime_factor = factor_ff;
   assign rsp_if.last_factor  = last_ff;
   assign rsp_if.no_factors   = none_ff;

endmodule
